### rtl/evr_pkg.sv
// Package for the viewport remapper: widths, CORDIC angle table, register indexes.
// No dependencies.
package evr_pkg;
   localparam int SrcColW = 11;
   localparam int SrcRowW = 10;
   localparam int PixW = 24;
   localparam int ViewColW = 10;
   localparam int ViewRowW = 9;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 16;
   localparam int Steps = 15;
   localparam int ViewWidth = 513;
   localparam int ViewHeight = 257;
   localparam int AngHalf = 32768;
   localparam int AngQuarter = 16384;
   localparam logic signed [27:0] GainInvQ24 = 28'sd10188014;
   localparam logic signed [17:0] GainInvQ16 = 18'sd39797;

   typedef enum logic [CsrIdxW-1:0] {
      REG_COS_PAN = 3'd0, REG_SIN_PAN = 3'd1, REG_COS_TILT = 3'd2,
      REG_SIN_TILT = 3'd3, REG_BOX_MIN_X = 3'd4, REG_BOX_MAX_X = 3'd5,
      REG_BOX_MIN_Y = 3'd6, REG_BOX_MAX_Y = 3'd7
   } reg_idx_type;

   // Rotation cell state: Q24 vector, residual angle
   typedef struct packed {
      logic signed [27:0] x;
      logic signed [27:0] y;
      logic signed [17:0] z;
      logic flip;
   } rot_type;

   // Vectoring cell state
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [18:0] a;
   } vec_type;

   function automatic logic signed [17:0] atan_units(input logic [3:0] k);
      case (k)
         4'd0: atan_units = 18'sd8192;
         4'd1: atan_units = 18'sd4836;
         4'd2: atan_units = 18'sd2555;
         4'd3: atan_units = 18'sd1297;
         4'd4: atan_units = 18'sd651;
         4'd5: atan_units = 18'sd326;
         4'd6: atan_units = 18'sd163;
         4'd7: atan_units = 18'sd81;
         4'd8: atan_units = 18'sd41;
         4'd9: atan_units = 18'sd20;
         4'd10: atan_units = 18'sd10;
         4'd11: atan_units = 18'sd5;
         4'd12: atan_units = 18'sd3;
         4'd13: atan_units = 18'sd1;
         4'd14: atan_units = 18'sd1;
         default: atan_units = 18'sd0;
      endcase
   endfunction

   // round Q24 to Q1.14 with clamp
   function automatic logic signed [15:0] to_q14(input logic signed [27:0] v);
      logic signed [28:0] r;
      r = (29'(v) + 29'sd512) >>> 10;
      if (r > 29'sd16384) to_q14 = 16'sd16384;
      else if (r < -29'sd16384) to_q14 = -16'sd16384;
      else to_q14 = 16'(r);
   endfunction
endpackage

### rtl/evr_stream_if.sv
// Valid/ready channel interface carrying a payload of parameterized type.
// Depends on nothing.
interface evr_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/equirect_viewport_remap.sv
// Viewport remapper top: CORDIC cell rows, rotations, window test, output stage.
// Throughput is one pixel per cycle whenever the pipeline advances.
// The whole pipeline advances when the output register is empty or being taken.
// Depth is set by the three rows of 15 CORDIC cells plus prep, rounding, multiply and output stages.
// Reset (synchronous, active high) clears valid bits and loads default registers.
// Depends on evr_pkg, evr_rot_cell, evr_vec_cell.
module equirect_viewport_remap (
   input logic clock,
   input logic reset,
   input logic csr_valid,
   output logic csr_ready,
   input logic [evr_pkg::CsrIdxW-1:0] csr_index,
   input logic [evr_pkg::CsrDataW-1:0] csr_data,
   input logic req_valid,
   output logic req_ready,
   input logic [evr_pkg::SrcColW-1:0] req_src_col,
   input logic [evr_pkg::SrcRowW-1:0] req_src_row,
   input logic [evr_pkg::PixW-1:0] req_src_pixel,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic rsp_in_view,
   output logic [evr_pkg::ViewColW-1:0] rsp_view_col,
   output logic [evr_pkg::ViewRowW-1:0] rsp_view_row,
   output logic [evr_pkg::PixW-1:0] rsp_view_pixel
);
   localparam int S = evr_pkg::Steps;
   // stage plan: 1 prep, S rot, 1 q14, 1 vec mult, 1 pan, 1 tilt, 1 vprep,
   // S vec1, 1 mag, 1 vprep2, S vec2, 1 window and out
   localparam int D = 3 * S + 9;

   // side-band carried along the whole line
   typedef struct packed {
      logic [evr_pkg::PixW-1:0] pix;
      logic in_box;
   } side_type;

   logic adv;
   logic [D-1:0] vld_ff;
   side_type side_ff [D];

   logic signed [15:0] cos_pan_ff, sin_pan_ff, cos_tilt_ff, sin_tilt_ff;
   logic [10:0] bminx_ff, bmaxx_ff;
   logic [9:0] bminy_ff, bmaxy_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_pan_ff <= 16'sd16384; sin_pan_ff <= '0;
         cos_tilt_ff <= 16'sd16384; sin_tilt_ff <= '0;
         bminx_ff <= '0; bmaxx_ff <= '1; bminy_ff <= '0; bmaxy_ff <= '1;
      end else if (csr_valid) begin
         case (evr_pkg::reg_idx_type'(csr_index))
            evr_pkg::REG_COS_PAN: cos_pan_ff <= csr_data;
            evr_pkg::REG_SIN_PAN: sin_pan_ff <= csr_data;
            evr_pkg::REG_COS_TILT: cos_tilt_ff <= csr_data;
            evr_pkg::REG_SIN_TILT: sin_tilt_ff <= csr_data;
            evr_pkg::REG_BOX_MIN_X: bminx_ff <= csr_data[10:0];
            evr_pkg::REG_BOX_MAX_X: bmaxx_ff <= csr_data[10:0];
            evr_pkg::REG_BOX_MIN_Y: bminy_ff <= csr_data[9:0];
            evr_pkg::REG_BOX_MAX_Y: bmaxy_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   assign adv = !vld_ff[D-1] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[D-2:0], req_valid};
   end

   // stage 0: angles, box test
   side_type side_in;
   evr_pkg::rot_type lon0_in, lat0_in;
   logic [15:0] lon_a, lat_a;
   always_comb begin
      side_in.pix = req_src_pixel;
      side_in.in_box = req_src_col >= bminx_ff && req_src_col <= bmaxx_ff &&
                       req_src_row >= bminy_ff && req_src_row <= bmaxy_ff;
      lon_a = {req_src_col, 5'd0} + 16'(evr_pkg::AngHalf);
      lat_a = {1'b0, req_src_row, 5'd0};
   end

   function automatic evr_pkg::rot_type rot_init(input logic [15:0] a);
      evr_pkg::rot_type r;
      logic signed [17:0] z;
      z = 18'(signed'(a));
      r.x = evr_pkg::GainInvQ24;
      r.y = '0;
      r.flip = 1'b0;
      if (z > 18'sd16384) begin
         z = z - 18'sd32768; r.flip = 1'b1;
      end else if (z < -18'sd16384) begin
         z = z + 18'sd32768; r.flip = 1'b1;
      end
      r.z = z;
      return r;
   endfunction

   always_comb begin
      lon0_in = rot_init(lon_a);
      lat0_in = rot_init(lat_a);
   end

   evr_pkg::rot_type lon_ff [S+1];
   evr_pkg::rot_type lat_ff [S+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         lon_ff[0] <= lon0_in;
         lat_ff[0] <= lat0_in;
         side_ff[0] <= side_in;
         for (int i = 1; i < D; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   for (genvar g = 0; g < S; g++) begin : g_rot
      evr_rot_cell u_lon (.clock(clock), .step(4'(g)), .adv(adv),
                          .d_in(lon_ff[g]), .d_ff(lon_ff[g+1]));
      evr_rot_cell u_lat (.clock(clock), .step(4'(g)), .adv(adv),
                          .d_in(lat_ff[g]), .d_ff(lat_ff[g+1]));
   end

   // q14 rounding
   logic signed [15:0] ct_ff, st_ff, cph_ff, sph_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ct_ff <= evr_pkg::to_q14(lon_ff[S].flip ? -lon_ff[S].x : lon_ff[S].x);
         st_ff <= evr_pkg::to_q14(lon_ff[S].flip ? -lon_ff[S].y : lon_ff[S].y);
         cph_ff <= evr_pkg::to_q14(lat_ff[S].flip ? -lat_ff[S].x : lat_ff[S].x);
         sph_ff <= evr_pkg::to_q14(lat_ff[S].flip ? -lat_ff[S].y : lat_ff[S].y);
      end
   end

   function automatic logic signed [23:0] rnd14(input logic signed [33:0] v);
      logic signed [33:0] t;
      t = (v + 34'sd8192) >>> 14;
      return t[23:0];
   endfunction

   logic signed [23:0] vx_ff, vy_ff, vz_ff, ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         vx_ff <= rnd14(34'(sph_ff) * 34'(ct_ff));
         vy_ff <= rnd14(34'(sph_ff) * 34'(st_ff));
         vz_ff <= 24'(cph_ff);
         ax_ff <= rnd14(34'(cos_pan_ff) * 34'(vx_ff) - 34'(sin_pan_ff) * 34'(vy_ff));
         ay_ff <= rnd14(34'(sin_pan_ff) * 34'(vx_ff) + 34'(cos_pan_ff) * 34'(vy_ff));
         az_ff <= vz_ff;
         bx_ff <= rnd14(34'(cos_tilt_ff) * 34'(ax_ff) + 34'(sin_tilt_ff) * 34'(az_ff));
         by_ff <= ay_ff;
         bz_ff <= rnd14(34'(cos_tilt_ff) * 34'(az_ff) - 34'(sin_tilt_ff) * 34'(ax_ff));
      end
   end

   function automatic evr_pkg::vec_type vec_init(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
      evr_pkg::vec_type r;
      r.x = x; r.y = y; r.a = '0;
      if (x < 0) begin
         r.a = (y >= 0) ? 19'sd32768 : -19'sd32768;
         r.x = -x; r.y = -y;
      end
      return r;
   endfunction

   // first vectoring row: longitude
   evr_pkg::vec_type v1_ff [S+1];
   logic [S:0] bxz_ff;
   logic signed [23:0] bz1_ff [S+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         v1_ff[0] <= vec_init(32'(bx_ff) <<< 8, 32'(by_ff) <<< 8);
         bxz_ff[0] <= bx_ff == 0;
         bz1_ff[0] <= bz_ff;
         for (int i = 1; i <= S; i++) begin
            bxz_ff[i] <= bxz_ff[i-1];
            bz1_ff[i] <= bz1_ff[i-1];
         end
      end
   end
   for (genvar g = 0; g < S; g++) begin : g_v1
      evr_vec_cell u_v (.clock(clock), .step(4'(g)), .adv(adv),
                        .d_in(v1_ff[g]), .d_ff(v1_ff[g+1]));
   end

   // magnitude
   logic signed [18:0] lon_m_ff;
   logic signed [31:0] rxy_ff;
   logic signed [23:0] bzm_ff;
   logic signed [49:0] magp;
   always_comb begin
      magp = (v1_ff[S].x < 0 ? 50'sd0 : 50'(v1_ff[S].x) * 50'(evr_pkg::GainInvQ16))
             + 50'sd32768;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         lon_m_ff <= bxz_ff[S] ? 19'sd16384 : v1_ff[S].a;
         rxy_ff <= 32'(magp >>> 16);
         bzm_ff <= bz1_ff[S];
      end
   end

   // second vectoring row: colatitude
   evr_pkg::vec_type v2_ff [S+1];
   logic signed [18:0] lon2_ff [S+1];
   logic [S:0] zero_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         v2_ff[0] <= vec_init(32'(bzm_ff) <<< 8, rxy_ff);
         lon2_ff[0] <= lon_m_ff;
         zero_ff[0] <= rxy_ff == 0 && bzm_ff == 0;
         for (int i = 1; i <= S; i++) begin
            lon2_ff[i] <= lon2_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
         end
      end
   end
   for (genvar g = 0; g < S; g++) begin : g_v2
      evr_vec_cell u_v (.clock(clock), .step(4'(g)), .adv(adv),
                        .d_in(v2_ff[g]), .d_ff(v2_ff[g+1]));
   end

   // window test and scaling
   logic signed [18:0] colat, lon_f;
   logic ok_in;
   logic [28:0] cprod, rprod;
   always_comb begin
      colat = zero_ff[S] ? 19'sd16384 : v2_ff[S].a;
      lon_f = lon2_ff[S];
      ok_in = side_ff[D-2].in_box && lon_f >= -19'sd8192 && lon_f <= 19'sd8192 &&
              colat >= 19'sd8192 && colat <= 19'sd24576;
      cprod = 29'(lon_f + 19'sd8192) * 29'(evr_pkg::ViewWidth) + 29'd8192;
      rprod = 29'(colat - 19'sd8192) * 29'(evr_pkg::ViewHeight) + 29'd8192;
   end

   logic ok_ff;
   logic [evr_pkg::ViewColW-1:0] col_ff;
   logic [evr_pkg::ViewRowW-1:0] row_ff;
   logic [evr_pkg::PixW-1:0] pix_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ok_ff <= ok_in;
         col_ff <= ok_in ? cprod[14 +: evr_pkg::ViewColW] : '0;
         row_ff <= ok_in ? rprod[14 +: evr_pkg::ViewRowW] : '0;
         pix_ff <= ok_in ? side_ff[D-2].pix : '0;
      end
   end

   assign rsp_valid = vld_ff[D-1];
   assign rsp_in_view = ok_ff;
   assign rsp_view_col = col_ff;
   assign rsp_view_row = row_ff;
   assign rsp_view_pixel = pix_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_view_col))
      else $error("output dropped while stalled");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_view |-> rsp_view_col == 0 && rsp_view_pixel == 0)
      else $error("out-of-view beat not cleared");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline stalled with empty output");
endmodule

### rtl/evr_rot_cell.sv
// One rotation-mode CORDIC cell: one micro-rotation per stage, registered.
// Depends on evr_pkg.
module evr_rot_cell (
   input logic clock,
   input logic [3:0] step,
   input logic adv,
   input evr_pkg::rot_type d_in,
   output evr_pkg::rot_type d_ff
);
   evr_pkg::rot_type d_nx_in;
   always_comb begin
      d_nx_in = d_in;
      if (d_in.z >= 0) begin
         d_nx_in.x = d_in.x - (d_in.y >>> step);
         d_nx_in.y = d_in.y + (d_in.x >>> step);
         d_nx_in.z = d_in.z - evr_pkg::atan_units(step);
      end else begin
         d_nx_in.x = d_in.x + (d_in.y >>> step);
         d_nx_in.y = d_in.y - (d_in.x >>> step);
         d_nx_in.z = d_in.z + evr_pkg::atan_units(step);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) d_ff <= d_nx_in;
   end
endmodule

### rtl/evr_vec_cell.sv
// One vectoring-mode CORDIC cell, registered.
// Depends on evr_pkg.
module evr_vec_cell (
   input logic clock,
   input logic [3:0] step,
   input logic adv,
   input evr_pkg::vec_type d_in,
   output evr_pkg::vec_type d_ff
);
   evr_pkg::vec_type d_nx_in;
   always_comb begin
      d_nx_in = d_in;
      if (d_in.y > 0) begin
         d_nx_in.x = d_in.x + (d_in.y >>> step);
         d_nx_in.y = d_in.y - (d_in.x >>> step);
         d_nx_in.a = d_in.a + 19'(evr_pkg::atan_units(step));
      end else begin
         d_nx_in.x = d_in.x - (d_in.y >>> step);
         d_nx_in.y = d_in.y + (d_in.x >>> step);
         d_nx_in.a = d_in.a - 19'(evr_pkg::atan_units(step));
      end
   end
   always_ff @(posedge clock) begin
      if (adv) d_ff <= d_nx_in;
   end
endmodule

### tb/sv/evr_tb_pkg.sv
// Beat layouts for the viewport remapper testbench channels.
// Depends on evr_pkg.
package evr_tb_pkg;
   typedef struct packed {
      logic [evr_pkg::SrcColW-1:0] col;
      logic [evr_pkg::SrcRowW-1:0] row;
      logic [evr_pkg::PixW-1:0] pixel;
   } src_beat_type;

   typedef struct packed {
      logic in_view;
      logic [evr_pkg::ViewColW-1:0] col;
      logic [evr_pkg::ViewRowW-1:0] row;
      logic [evr_pkg::PixW-1:0] pixel;
   } view_beat_type;

   typedef struct packed {
      evr_pkg::reg_idx_type index;
      logic [evr_pkg::CsrDataW-1:0] data;
   } csr_beat_type;
endpackage

### tb/sv/evr_remap_checker.sv
// Watches the register, pixel and viewport channels, predicts each viewport beat
// from its own fixed-point projection model and compares. Depends on evr_pkg, evr_tb_pkg.
module evr_remap_checker (
   input logic clock,
   input logic reset,
   input logic csr_valid,
   input logic csr_ready,
   input evr_tb_pkg::csr_beat_type csr_beat,
   input logic req_valid,
   input logic req_ready,
   input evr_tb_pkg::src_beat_type req_beat,
   input logic rsp_valid,
   input logic rsp_ready,
   input evr_tb_pkg::view_beat_type rsp_beat,
   output int errors,
   output int pending
);
   const longint ATAN_TAB[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                                  5, 3, 1, 1};

   logic signed [15:0] cos_pan, sin_pan, cos_tilt, sin_tilt;
   logic [10:0] box_x0, box_x1;
   logic [9:0] box_y0, box_y1;
   evr_tb_pkg::view_beat_type view_queue[$];

   function automatic longint round_q14(input longint v);
      longint r;
      r = (v + 512) >>> 10;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
   endfunction

   function automatic void angle_sin_cos(input longint a, output longint c, output longint s);
      longint z, x, y, nx;
      bit flip;
      z = a & 65535;
      x = 10188014;
      y = 0;
      flip = 0;
      if (z >= 32768) z -= 65536;
      if (z > 16384) begin
         z -= 32768;
         flip = 1;
      end else if (z < -16384) begin
         z += 32768;
         flip = 1;
      end
      for (int k = 0; k < 15; k++) begin
         if (z >= 0) begin
            nx = x - (y >>> k);
            y = y + (x >>> k);
            z -= ATAN_TAB[k];
         end else begin
            nx = x + (y >>> k);
            y = y - (x >>> k);
            z += ATAN_TAB[k];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = round_q14(x);
      s = round_q14(y);
   endfunction

   function automatic void vector_angle(input longint xi, input longint yi,
                                        output longint ang, output longint mag);
      longint x, y, a, nx;
      x = xi;
      y = yi;
      a = 0;
      if (x < 0) begin
         a = (y >= 0) ? 32768 : -32768;
         x = -x;
         y = -y;
      end
      for (int k = 0; k < 15; k++) begin
         if (y > 0) begin
            nx = x + (y >>> k);
            y = y - (x >>> k);
            a += ATAN_TAB[k];
         end else begin
            nx = x - (y >>> k);
            y = y + (x >>> k);
            a -= ATAN_TAB[k];
         end
         x = nx;
      end
      if (x < 0) x = 0;
      ang = a;
      mag = (x * 39797 + 32768) >>> 16;
   endfunction

   function automatic evr_tb_pkg::view_beat_type project_pixel(
         input evr_tb_pkg::src_beat_type s);
      evr_tb_pkg::view_beat_type v;
      longint ct, st, cph, sph, vx, vy, vz, ax, ay, bx, by, bz, lon, colat, rxy, unused;
      longint cp, sp, ctl, stl;
      bit in_box, in_win;
      cp = cos_pan;
      sp = sin_pan;
      ctl = cos_tilt;
      stl = sin_tilt;
      angle_sin_cos((longint'(s.col) * 32 + 32768) & 65535, ct, st);
      angle_sin_cos((longint'(s.row) * 32) & 65535, cph, sph);
      vx = (sph * ct + 8192) >>> 14;
      vy = (sph * st + 8192) >>> 14;
      vz = cph;
      ax = (cp * vx - sp * vy + 8192) >>> 14;
      ay = (sp * vx + cp * vy + 8192) >>> 14;
      bx = (ctl * ax + stl * vz + 8192) >>> 14;
      by = ay;
      bz = (ctl * vz - stl * ax + 8192) >>> 14;
      vector_angle(bx * 256, by * 256, lon, rxy);
      if (bx == 0) lon = 16384;
      if (rxy == 0 && bz == 0) colat = 16384;
      else vector_angle(bz * 256, rxy, colat, unused);
      in_box = s.col >= box_x0 && s.col <= box_x1 && s.row >= box_y0 && s.row <= box_y1;
      in_win = lon >= -8192 && lon <= 8192 && colat >= 8192 && colat <= 24576;
      v = '0;
      if (in_box && in_win) begin
         v.in_view = 1'b1;
         v.col = evr_pkg::ViewColW'(((lon + 8192) * evr_pkg::ViewWidth + 8192) >>> 14);
         v.row = evr_pkg::ViewRowW'(((colat - 8192) * evr_pkg::ViewHeight + 8192) >>> 14);
         v.pixel = s.pixel;
      end
      return v;
   endfunction

   assign pending = view_queue.size();

   initial errors = 0;

   always @(posedge clock) begin
      evr_tb_pkg::view_beat_type want;
      if (reset) begin
         cos_pan <= 16'sd16384;
         sin_pan <= 16'sd0;
         cos_tilt <= 16'sd16384;
         sin_tilt <= 16'sd0;
         box_x0 <= '0;
         box_x1 <= 11'd2047;
         box_y0 <= '0;
         box_y1 <= 10'd1023;
         view_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_beat.index)
               evr_pkg::REG_COS_PAN: cos_pan <= csr_beat.data;
               evr_pkg::REG_SIN_PAN: sin_pan <= csr_beat.data;
               evr_pkg::REG_COS_TILT: cos_tilt <= csr_beat.data;
               evr_pkg::REG_SIN_TILT: sin_tilt <= csr_beat.data;
               evr_pkg::REG_BOX_MIN_X: box_x0 <= csr_beat.data[10:0];
               evr_pkg::REG_BOX_MAX_X: box_x1 <= csr_beat.data[10:0];
               evr_pkg::REG_BOX_MIN_Y: box_y0 <= csr_beat.data[9:0];
               evr_pkg::REG_BOX_MAX_Y: box_y1 <= csr_beat.data[9:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) view_queue.push_back(project_pixel(req_beat));
         if (rsp_valid && rsp_ready) begin
            if (view_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected viewport beat %p", $time, rsp_beat);
            end else begin
               want = view_queue.pop_front();
               if (want.in_view !== rsp_beat.in_view) begin
                  errors++;
                  $display("%0t: in_view expected %0d actual %0d", $time, want.in_view,
                           rsp_beat.in_view);
               end
               if (want.col !== rsp_beat.col) begin
                  errors++;
                  $display("%0t: view_col expected %0d actual %0d", $time, want.col,
                           rsp_beat.col);
               end
               if (want.row !== rsp_beat.row) begin
                  errors++;
                  $display("%0t: view_row expected %0d actual %0d", $time, want.row,
                           rsp_beat.row);
               end
               if (want.pixel !== rsp_beat.pixel) begin
                  errors++;
                  $display("%0t: view_pixel expected %h actual %h", $time, want.pixel,
                           rsp_beat.pixel);
               end
            end
         end
      end
   end
endmodule

### tb/sv/testbench.sv
// Top of the viewport remapper testbench: clock, reset, register phases, pixel
// stimulus and verdict. Depends on evr_pkg, evr_tb_pkg, evr_stream_if, the remapper and the checker.
module testbench;
   logic clock = 0;
   logic reset = 1;
   int errors, pending, cycles = 0;
   int sent = 0, send_pct = 31, recv_pct = 71;

   evr_stream_if #(.payload_type(evr_tb_pkg::csr_beat_type)) csr_ch (clock);
   evr_stream_if #(.payload_type(evr_tb_pkg::src_beat_type)) req_ch (clock);
   evr_stream_if #(.payload_type(evr_tb_pkg::view_beat_type)) rsp_ch (clock);

   equirect_viewport_remap u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_ch.valid), .csr_ready(csr_ch.ready),
      .csr_index(csr_ch.data.index), .csr_data(csr_ch.data.data),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_src_col(req_ch.data.col), .req_src_row(req_ch.data.row),
      .req_src_pixel(req_ch.data.pixel),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_in_view(rsp_ch.data.in_view), .rsp_view_col(rsp_ch.data.col),
      .rsp_view_row(rsp_ch.data.row), .rsp_view_pixel(rsp_ch.data.pixel)
   );

   evr_remap_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_valid(csr_ch.valid), .csr_ready(csr_ch.ready), .csr_beat(csr_ch.data),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_beat(req_ch.data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_beat(rsp_ch.data),
      .errors(errors), .pending(pending)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_pct);

   initial begin
      csr_ch.valid = 0;
      csr_ch.data = '0;
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
   end

   task automatic send_pixel(input logic [10:0] col, input logic [9:0] row,
                             input logic [23:0] pix);
      while ($urandom_range(99) < send_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= '{col: col, row: row, pixel: pix};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
      if (sent == 517) begin
         send_pct = 71;
         recv_pct = 31;
      end else if (sent == 1034) begin
         send_pct = 0;
         recv_pct = 0;
      end
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_reg(input evr_pkg::reg_idx_type idx, input logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= '{index: idx, data: value};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic set_view(input logic [15:0] cp, input logic [15:0] sp,
                           input logic [15:0] ct, input logic [15:0] st,
                           input logic [10:0] x0, input logic [10:0] x1,
                           input logic [9:0] y0, input logic [9:0] y1);
      write_reg(evr_pkg::REG_COS_PAN, cp);
      write_reg(evr_pkg::REG_SIN_PAN, sp);
      write_reg(evr_pkg::REG_COS_TILT, ct);
      write_reg(evr_pkg::REG_SIN_TILT, st);
      write_reg(evr_pkg::REG_BOX_MIN_X, 16'(x0));
      write_reg(evr_pkg::REG_BOX_MAX_X, 16'(x1));
      write_reg(evr_pkg::REG_BOX_MIN_Y, 16'(y0));
      write_reg(evr_pkg::REG_BOX_MAX_Y, 16'(y1));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] q14(input real v);
      return 16'($rtoi($floor(16384.0 * v + 0.5)));
   endfunction

   task automatic random_pixels(input int n);
      logic [10:0] c;
      logic [9:0] r;
      for (int i = 0; i < n; i++) begin
         c = 11'($urandom_range(2047));
         r = 10'($urandom_range(1023));
         send_pixel(c, r, 24'($urandom));
      end
   endtask

   initial begin
      int cols[5] = '{0, 512, 1024, 1536, 2047};
      int rows[4] = '{0, 256, 512, 1023};
      real pan, tilt;
      int x0, y0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (cols[i])
         foreach (rows[j])
            send_pixel(11'(cols[i]), 10'(rows[j]),
                       ((i + j) % 2) ? 24'hFFFFFF : 24'h000000);
      drain();
      // extremes: half-turn pan, straight up and down tilt, out-of-range registers
      set_view(16'hC000, 16'h0000, 16'h0000, 16'h4000, 11'd0, 11'd2047, 10'd0, 10'd1023);
      random_pixels(120);
      drain();
      set_view(16'h4000, 16'h0000, 16'h0000, 16'hC000, 11'd0, 11'd2047, 10'd0, 10'd1023);
      random_pixels(120);
      drain();
      set_view(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 11'd0, 11'd2047, 10'd0, 10'd1023);
      random_pixels(120);
      drain();
      // empty box
      set_view(16'h4000, 16'h0000, 16'h4000, 16'h0000, 11'd2047, 11'd0, 10'd1023, 10'd0);
      random_pixels(60);
      drain();
      // single-pixel box in the middle of the view
      set_view(16'h4000, 16'h0000, 16'h4000, 16'h0000, 11'd1024, 11'd1024, 10'd512,
               10'd512);
      send_pixel(11'd1024, 10'd512, 24'hA5A5A5);
      send_pixel(11'd1023, 10'd512, 24'h5A5A5A);
      drain();
      for (int p = 0; p < 9; p++) begin
         pan = $urandom_range(359) * 3.14159265358979 / 180.0;
         tilt = ($urandom_range(180) - 90.0) * 3.14159265358979 / 180.0;
         x0 = $urandom_range(1023);
         y0 = $urandom_range(511);
         if (p % 3 == 0) set_view(q14($cos(pan)), q14($sin(pan)), q14($cos(tilt)),
                                  q14($sin(tilt)), 11'd0, 11'd2047, 10'd0, 10'd1023);
         else set_view(q14($cos(pan)), q14($sin(pan)), q14($cos(tilt)), q14($sin(tilt)),
                       11'(x0), 11'(x0 + $urandom_range(1024)),
                       10'(y0), 10'(y0 + $urandom_range(512)));
         random_pixels(125);
         drain();
      end
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
